@@ rtl/core/dirty_rect_tracker_assert.svh @@
// assertion macros for the dirty rectangle tracker
`ifndef DIRTY_RECT_TRACKER_ASSERT_SVH
`define DIRTY_RECT_TRACKER_ASSERT_SVH

// same-cycle implication
`define DRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/drt_pkg.sv @@
// types, codes and constants shared by the dirty rectangle tracker
package drt_pkg;

	localparam int MAX_RECTS_DEF  = 16;
	localparam int COORD_BITS_DEF = 12;
	localparam int IN_START_W     = 12;
	localparam int IN_END_W       = 13;
	localparam int OUT_W          = 13;
	localparam int TOTAL_W        = 5;

	typedef enum logic [2:0] {
		REQ_MARK   = 3'd0,
		REQ_CURSOR = 3'd1,
		REQ_SCROLL = 3'd2,
		REQ_REPORT = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD_A,
		ST_CMP_B,
		ST_UPD_B,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic [2:0]            req_type;
		logic [IN_START_W-1:0] first_row;
		logic [IN_END_W-1:0]   end_row;
		logic [IN_START_W-1:0] first_col;
		logic [IN_END_W-1:0]   end_col;
		logic [IN_START_W-1:0] old_row;
		logic [IN_START_W-1:0] old_col;
		logic                  visible;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0]   out_start_row;
		logic [OUT_W-1:0]   out_end_row;
		logic [OUT_W-1:0]   out_start_col;
		logic [OUT_W-1:0]   out_end_col;
		logic [OUT_W-1:0]   span_start;
		logic [OUT_W-1:0]   span_end;
		logic [TOTAL_W-1:0] rect_total;
		logic               overflowed;
		logic               history_dirty;
		logic               cursor_changed;
		logic               cursor_shown;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic upd;
		logic cmp_b;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_cursor;
		logic rpt_last;
	} sts_t;

endpackage

@@ rtl/core/drt_ctrl.sv @@
// request sequencer of the dirty rectangle tracker
module drt_ctrl import drt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] req_type,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_type) inside
						REQ_MARK, REQ_CURSOR: state_d = ST_UPD_A;
						REQ_REPORT:           state_d = ST_REPORT;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPD_A:  state_d = sts.is_cursor ? ST_CMP_B : ST_IDLE;
			ST_CMP_B:  state_d = ST_UPD_B;
			ST_UPD_B:  state_d = ST_IDLE;
			ST_REPORT: state_d = sts.rpt_last ? ST_IDLE : ST_REPORT;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		busy      = (state_q != ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.upd   = (state_q == ST_UPD_A) || (state_q == ST_UPD_B);
		cmd.cmp_b = (state_q == ST_CMP_B);
		cmd.emit  = (state_q == ST_REPORT);
	end

endmodule

@@ rtl/core/drt_datapath.sv @@
// rectangle table, summary flags and result register of the dirty rectangle tracker
module drt_datapath import drt_pkg::*; #(
	parameter int MAX_RECTS  = MAX_RECTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  item,
	output sts_t      sts,
	output out_item_t rsp,
	output logic      rsp_stb
);

	localparam int EW  = COORD_BITS + 1;
	localparam int IW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNW = $clog2(MAX_RECTS + 1);
	localparam logic [EW-1:0]  SMASK = {1'b0, {COORD_BITS{1'b1}}};
	localparam logic [EW-1:0]  ONE   = EW'(1);
	localparam logic [CNW-1:0] FULL  = CNW'(MAX_RECTS);

	logic [EW-1:0] r0_q [MAX_RECTS];
	logic [EW-1:0] r1_q [MAX_RECTS];
	logic [EW-1:0] c0_q [MAX_RECTS];
	logic [EW-1:0] c1_q [MAX_RECTS];

	logic [CNW-1:0]       count_q;
	logic                 ovf_q;
	logic                 span_v_q;
	logic [EW-1:0]        span_lo_q;
	logic [EW-1:0]        span_hi_q;
	logic                 hist_q;
	logic                 curs_q;
	logic                 vis_q;
	logic [2:0]           type_q;
	logic [EW-1:0]        nrow_q;
	logic [EW-1:0]        ncol_q;
	logic [EW-1:0]        box_r0_q;
	logic [EW-1:0]        box_r1_q;
	logic [EW-1:0]        box_c0_q;
	logic [EW-1:0]        box_c1_q;
	logic                 box_ok_q;
	logic [MAX_RECTS-1:0] hit_q;
	logic [IW-1:0]        idx_q;
	out_item_t            rsp_q;
	logic                 rsp_stb_q;

	logic [EW-1:0]        in_sr, in_er, in_sc, in_ec, in_or, in_oc;
	logic [EW-1:0]        cand_r0, cand_r1, cand_c0, cand_c1;
	logic                 cand_rows;
	logic                 grow;
	logic [MAX_RECTS-1:0] hit_d;
	logic [IW-1:0]        sel;
	logic                 any_hit;
	logic [EW-1:0]        wr_r0, wr_r1, wr_c0, wr_c1;
	logic [IW-1:0]        wr_idx;
	logic                 wr_en;
	logic                 full;
	logic                 rpt_last;
	out_item_t            rsp_d;

	assign in_sr = EW'(item.first_row) & SMASK;
	assign in_sc = EW'(item.first_col) & SMASK;
	assign in_or = EW'(item.old_row) & SMASK;
	assign in_oc = EW'(item.old_col) & SMASK;
	assign in_er = EW'(item.end_row);
	assign in_ec = EW'(item.end_col);

	// box to compare: request box or old cursor cell at load, new cursor cell later
	always_comb begin
		if (cmd.load && (item.req_type == REQ_CURSOR)) begin
			cand_r0 = in_or;
			cand_r1 = in_or + ONE;
			cand_c0 = in_oc;
			cand_c1 = in_oc + ONE;
		end else if (cmd.load) begin
			cand_r0 = in_sr;
			cand_r1 = in_er;
			cand_c0 = in_sc;
			cand_c1 = in_ec;
		end else begin
			cand_r0 = nrow_q;
			cand_r1 = nrow_q + ONE;
			cand_c0 = ncol_q;
			cand_c1 = ncol_q + ONE;
		end
	end

	assign cand_rows = cand_r1 > cand_r0;
	assign grow = cand_rows && (cmd.cmp_b || (cmd.load &&
		((item.req_type == REQ_MARK) || (item.req_type == REQ_CURSOR))));

	always_comb begin
		for (int i = 0; i < MAX_RECTS; i++) begin
			hit_d[i] = (CNW'(i) < count_q)
				&& !((r1_q[i] < cand_r0) || (cand_r1 < r0_q[i]))
				&& !((c1_q[i] < cand_c0) || (cand_c1 < c0_q[i]));
		end
	end

	// first matching entry
	always_comb begin
		sel = '0;
		for (int i = MAX_RECTS - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				sel = IW'(i);
			end
		end
	end

	assign any_hit = |hit_q;
	assign full    = (count_q == FULL);

	always_comb begin
		if (any_hit) begin
			wr_idx = sel;
			wr_r0  = (box_r0_q < r0_q[sel]) ? box_r0_q : r0_q[sel];
			wr_r1  = (box_r1_q > r1_q[sel]) ? box_r1_q : r1_q[sel];
			wr_c0  = (box_c0_q < c0_q[sel]) ? box_c0_q : c0_q[sel];
			wr_c1  = (box_c1_q > c1_q[sel]) ? box_c1_q : c1_q[sel];
		end else begin
			wr_idx = count_q[IW-1:0];
			wr_r0  = box_r0_q;
			wr_r1  = box_r1_q;
			wr_c0  = box_c0_q;
			wr_c1  = box_c1_q;
		end
	end

	assign wr_en = cmd.upd && box_ok_q && (any_hit || !full);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			r0_q[wr_idx] <= wr_r0;
			r1_q[wr_idx] <= wr_r1;
			c0_q[wr_idx] <= wr_c0;
			c1_q[wr_idx] <= wr_c1;
		end
		if (cmd.load || cmd.cmp_b) begin
			box_r0_q <= cand_r0;
			box_r1_q <= cand_r1;
			box_c0_q <= cand_c0;
			box_c1_q <= cand_c1;
			box_ok_q <= cand_rows && (cand_c1 > cand_c0);
			hit_q    <= hit_d;
		end
		if (cmd.load) begin
			type_q <= item.req_type;
			nrow_q <= in_sr;
			ncol_q <= in_sc;
		end
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			span_v_q  <= 1'b0;
			span_lo_q <= '0;
			span_hi_q <= '0;
			hist_q    <= 1'b0;
			curs_q    <= 1'b0;
			vis_q     <= 1'b1;
			idx_q     <= '0;
			rsp_stb_q <= 1'b0;
		end else begin
			rsp_stb_q <= cmd.emit;
			if (grow) begin
				span_v_q <= 1'b1;
				if (!span_v_q || (cand_r0 < span_lo_q)) begin
					span_lo_q <= cand_r0;
				end
				if (!span_v_q || (cand_r1 > span_hi_q)) begin
					span_hi_q <= cand_r1;
				end
			end
			if (cmd.upd && box_ok_q && !any_hit) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNW'(1);
				end
			end
			if (cmd.load) begin
				case (item.req_type)
					REQ_CURSOR: begin
						curs_q <= 1'b1;
						vis_q  <= item.visible;
					end
					REQ_SCROLL: hist_q <= 1'b1;
					REQ_REPORT: idx_q <= '0;
					REQ_CLEAR: begin
						count_q   <= '0;
						ovf_q     <= 1'b0;
						span_v_q  <= 1'b0;
						span_lo_q <= '0;
						span_hi_q <= '0;
						hist_q    <= 1'b0;
						curs_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.emit && !rpt_last) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign rpt_last = (count_q == '0) || ((CNW'(idx_q) + CNW'(1)) == count_q);

	always_comb begin
		rsp_d                = '0;
		rsp_d.span_start     = span_v_q ? OUT_W'(span_lo_q) : '0;
		rsp_d.span_end       = span_v_q ? OUT_W'(span_hi_q) : '0;
		rsp_d.overflowed     = ovf_q;
		rsp_d.history_dirty  = hist_q;
		rsp_d.cursor_changed = curs_q;
		rsp_d.cursor_shown   = vis_q;
		rsp_d.last           = rpt_last;
		if (count_q != '0) begin
			rsp_d.out_start_row = OUT_W'(r0_q[idx_q]);
			rsp_d.out_end_row   = OUT_W'(r1_q[idx_q]);
			rsp_d.out_start_col = OUT_W'(c0_q[idx_q]);
			rsp_d.out_end_col   = OUT_W'(c1_q[idx_q]);
			rsp_d.rect_total    = TOTAL_W'(count_q);
		end else if (span_v_q && (span_hi_q > span_lo_q) && !ovf_q) begin
			// whole dirty rows stand in for the empty table
			rsp_d.out_start_row = OUT_W'(span_lo_q);
			rsp_d.out_end_row   = OUT_W'(span_hi_q);
			rsp_d.rect_total    = TOTAL_W'(1);
		end
	end

	assign sts.is_cursor = (type_q == REQ_CURSOR);
	assign sts.rpt_last  = rpt_last;
	assign rsp           = rsp_q;
	assign rsp_stb       = rsp_stb_q;

endmodule

@@ rtl/core/dirty_rect_tracker.sv @@
// top level of the dirty rectangle tracker
//
// A request item is taken at a rising edge with start high and busy low.
// Request kinds: mark rectangle, cursor move, scrollback pushed, report, clear.
// After the accepting edge busy stays high while a mark updates, a cursor
// move updates, compares and updates again, or a report emits its results;
// scrollback, clear and unknown codes leave busy low. Each mark or cell
// is compared against the whole table and at most one entry is updated in
// the next cycle; a cursor move does this for the old cell and then the new.
// A report gives N results (N stored rectangles, or 1 when the table is
// empty) on rsp with rsp_stb high for one cycle each, in consecutive cycles,
// the first one strobed after the sequencer enters its report state and
// the strobe register follows; the final one has rsp.last set. Results are
// not held: the receiver takes each one in its strobe cycle.
// Reset empties the table, clears span and flags and shows the cursor; the
// table itself is not swept, entries past the count are never read.
`include "dirty_rect_tracker_assert.svh"

module dirty_rect_tracker import drt_pkg::*; #(
	parameter int MAX_RECTS  = MAX_RECTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  req,
	output logic      busy,
	output out_item_t rsp,
	output logic      rsp_stb
);

	cmd_t cmd;
	sts_t sts;

	drt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	drt_datapath #(
		.MAX_RECTS  (MAX_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.item    (req),
		.sts     (sts),
		.rsp     (rsp),
		.rsp_stb (rsp_stb)
	);

	`DRT_ASSERT_NEXT(a_gap_after_last, clk, arst_n, rsp_stb && rsp.last, !rsp_stb, "item after last")
	`DRT_ASSERT_NEXT(a_report_burst, clk, arst_n, rsp_stb && !rsp.last, rsp_stb, "report gap")
	`DRT_ASSERT_NEXT(a_report_busy, clk, arst_n, start && !busy && req.req_type == REQ_REPORT, busy, "report not busy")

endmodule

@@ tb/sv/tb_dirty_rect_tracker.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the dirty rectangle tracker, directed and random request items
module tb_dirty_rect_tracker;
	import drt_pkg::*;

	localparam int          MAX_BOXES       = MAX_RECTS_DEF;
	localparam int          STALL_LIMIT     = 2000;
	localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;
	localparam logic [11:0] COORD_MAX       = 12'd4095;
	localparam logic [12:0] END_MAX         = 13'd4096;

	typedef struct packed {
		logic [12:0] r0;
		logic [12:0] r1;
		logic [12:0] c0;
		logic [12:0] c1;
	} dmg_box_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	in_item_t  req;
	logic      busy;
	out_item_t rsp;
	logic      rsp_stb;

	dmg_box_t    box_tab [MAX_BOXES];
	int          box_count;
	bit          box_dropped;
	bit          rows_valid;
	logic [12:0] rows_lo;
	logic [12:0] rows_hi;
	bit          hist_dirty;
	bit          cur_dirty;
	bit          cur_shown;

	out_item_t expected_rsp [$];
	int idle_pct = 0;
	int n_items = 0;
	int n_reports = 0;
	int n_full_reports = 0;
	int n_results = 0;
	int n_errors = 0;
	int stall_cycles = 0;

	dirty_rect_tracker DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.rsp     (rsp),
		.rsp_stb (rsp_stb)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_damage();
		box_count = 0;
		box_dropped = 1'b0;
		rows_valid = 1'b0;
		rows_lo = '0;
		rows_hi = '0;
		hist_dirty = 1'b0;
		cur_dirty = 1'b0;
	endfunction

	function automatic void grow_rows(logic [12:0] lo, logic [12:0] hi);
		if (hi <= lo)
			return;
		if (!rows_valid) begin
			rows_valid = 1'b1;
			rows_lo = lo;
			rows_hi = hi;
		end else begin
			if (lo < rows_lo)
				rows_lo = lo;
			if (hi > rows_hi)
				rows_hi = hi;
		end
	endfunction

	function automatic void merge_box(logic [12:0] r0, logic [12:0] r1,
			logic [12:0] c0, logic [12:0] c1);
		if (r1 <= r0 || c1 <= c0)
			return;
		for (int i = 0; i < box_count; i++) begin
			if (box_tab[i].r1 < r0 || r1 < box_tab[i].r0)
				continue;
			if (box_tab[i].c1 < c0 || c1 < box_tab[i].c0)
				continue;
			if (r0 < box_tab[i].r0)
				box_tab[i].r0 = r0;
			if (r1 > box_tab[i].r1)
				box_tab[i].r1 = r1;
			if (c0 < box_tab[i].c0)
				box_tab[i].c0 = c0;
			if (c1 > box_tab[i].c1)
				box_tab[i].c1 = c1;
			return;
		end
		if (box_count >= MAX_BOXES) begin
			box_dropped = 1'b1;
			return;
		end
		box_tab[box_count] = '{r0, r1, c0, c1};
		box_count++;
	endfunction

	function automatic void push_rect(dmg_box_t b, logic [4:0] total, bit is_last);
		out_item_t o;
		o.out_start_row  = b.r0;
		o.out_end_row    = b.r1;
		o.out_start_col  = b.c0;
		o.out_end_col    = b.c1;
		o.span_start     = rows_valid ? rows_lo : '0;
		o.span_end       = rows_valid ? rows_hi : '0;
		o.rect_total     = total;
		o.overflowed     = box_dropped;
		o.history_dirty  = hist_dirty;
		o.cursor_changed = cur_dirty;
		o.cursor_shown   = cur_shown;
		o.last           = is_last;
		expected_rsp.push_back(o);
	endfunction

	function automatic void apply_request(in_item_t it);
		logic [12:0] orow;
		logic [12:0] ocol;
		logic [12:0] nrow;
		logic [12:0] ncol;
		orow = {1'b0, it.old_row};
		ocol = {1'b0, it.old_col};
		nrow = {1'b0, it.first_row};
		ncol = {1'b0, it.first_col};
		case (it.req_type)
			REQ_MARK: begin
				grow_rows(nrow, it.end_row);
				merge_box(nrow, it.end_row, ncol, it.end_col);
			end
			REQ_CURSOR: begin
				cur_dirty = 1'b1;
				cur_shown = it.visible;
				grow_rows(orow, orow + 13'd1);
				grow_rows(nrow, nrow + 13'd1);
				merge_box(orow, orow + 13'd1, ocol, ocol + 13'd1);
				merge_box(nrow, nrow + 13'd1, ncol, ncol + 13'd1);
			end
			REQ_SCROLL: begin
				hist_dirty = 1'b1;
			end
			REQ_REPORT: begin
				n_reports++;
				if (box_dropped)
					n_full_reports++;
				if (box_count > 0) begin
					for (int i = 0; i < box_count; i++)
						push_rect(box_tab[i], 5'(box_count), i + 1 == box_count);
				end else if (rows_valid && rows_hi > rows_lo && !box_dropped) begin
					push_rect('{rows_lo, rows_hi, 13'd0, 13'd0}, 5'd1, 1'b1);
				end else begin
					push_rect('0, 5'd0, 1'b1);
				end
			end
			REQ_CLEAR: begin
				clear_damage();
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string fname, logic [12:0] want, logic [12:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= 10)
				$display("ERROR at %0t: %s expected %0d got %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		out_item_t want;
		if (arst_n && rsp_stb) begin
			n_results++;
			if (expected_rsp.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR at %0t: result with none expected", $time);
			end else begin
				want = expected_rsp.pop_front();
				check_field("out_start_row", want.out_start_row, rsp.out_start_row);
				check_field("out_end_row", want.out_end_row, rsp.out_end_row);
				check_field("out_start_col", want.out_start_col, rsp.out_start_col);
				check_field("out_end_col", want.out_end_col, rsp.out_end_col);
				check_field("span_start", want.span_start, rsp.span_start);
				check_field("span_end", want.span_end, rsp.span_end);
				check_field("rect_total", 13'(want.rect_total), 13'(rsp.rect_total));
				check_field("overflowed", 13'(want.overflowed), 13'(rsp.overflowed));
				check_field("history_dirty", 13'(want.history_dirty),
					13'(rsp.history_dirty));
				check_field("cursor_changed", 13'(want.cursor_changed),
					13'(rsp.cursor_changed));
				check_field("cursor_shown", 13'(want.cursor_shown), 13'(rsp.cursor_shown));
				check_field("last", 13'(want.last), 13'(rsp.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_stb)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item or result for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= it;
		do begin
			@(posedge clk);
		end while (busy);
		apply_request(it);
		if (it.req_type <= REQ_CLEAR)
			n_items++;
	endtask

	function automatic in_item_t mk_item(logic [2:0] kind, int sr, int er, int sc, int ec,
			int orow, int ocol, bit vis);
		in_item_t it;
		it.req_type  = kind;
		it.first_row = 12'(sr);
		it.end_row   = 13'(er);
		it.first_col = 12'(sc);
		it.end_col   = 13'(ec);
		it.old_row   = 12'(orow);
		it.old_col   = 12'(ocol);
		it.visible   = vis;
		return it;
	endfunction

	function automatic logic [11:0] rand_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return COORD_MAX;
			default: return 12'($urandom_range(COORD_MAX));
		endcase
	endfunction

	function automatic logic [12:0] rand_end();
		case ($urandom_range(9))
			0: return '0;
			1: return END_MAX;
			default: return 13'($urandom_range(END_MAX));
		endcase
	endfunction

	// most marks and cursor moves stay in a small corner for merges, touches and a full table
	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		it.first_row = rand_coord();
		it.end_row   = rand_end();
		it.first_col = rand_coord();
		it.end_col   = rand_end();
		it.old_row   = rand_coord();
		it.old_col   = rand_coord();
		it.visible   = 1'($urandom_range(1));
		if (pick < 48) begin
			it.req_type = REQ_MARK;
			if ($urandom_range(3) != 0) begin
				it.first_row = 12'($urandom_range(60));
				it.first_col = 12'($urandom_range(60));
				it.end_row   = 13'(it.first_row) + 13'($urandom_range(4));
				it.end_col   = 13'(it.first_col) + 13'($urandom_range(4));
				if ($urandom_range(15) == 0)
					it.end_row = 13'($urandom_range(it.first_row));
			end
		end else if (pick < 63) begin
			it.req_type = REQ_CURSOR;
			if ($urandom_range(3) != 0) begin
				it.first_row = 12'($urandom_range(60));
				it.first_col = 12'($urandom_range(60));
				it.old_row   = 12'($urandom_range(60));
				it.old_col   = 12'($urandom_range(60));
			end
		end else if (pick < 68) begin
			it.req_type = REQ_SCROLL;
		end else if (pick < 86) begin
			it.req_type = REQ_REPORT;
		end else if (pick < 92) begin
			it.req_type = REQ_CLEAR;
		end else begin
			it.req_type = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
		end
		return it;
	endfunction

	task automatic test_empty_and_span();
		send_item(mk_item(REQ_REPORT, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(REQ_MARK, 10, 20, 5, 5, 0, 0, 1'b0));
		send_item(mk_item(REQ_REPORT, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(REQ_MARK, 30, 30, 0, 10, 0, 0, 1'b0));
	endtask

	task automatic test_merge_and_cursor();
		send_item(mk_item(REQ_MARK, 0, 1, 0, 1, 0, 0, 1'b0));
		send_item(mk_item(REQ_MARK, 1, 2, 1, 2, 0, 0, 1'b0));
		send_item(mk_item(REQ_MARK, int'(COORD_MAX), int'(END_MAX), int'(COORD_MAX),
			int'(END_MAX), 0, 0, 1'b0));
		send_item(mk_item(REQ_CURSOR, 0, 0, int'(COORD_MAX), 0, int'(COORD_MAX), 0, 1'b0));
		send_item(mk_item(REQ_SCROLL, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(REQ_REPORT, 0, 0, 0, 0, 0, 0, 1'b1));
		send_item(mk_item(REQ_SPARE_FIRST, 1, 2, 1, 2, 0, 0, 1'b1));
		send_item(mk_item(REQ_SPARE_LAST, 1, 2, 1, 2, 0, 0, 1'b1));
		send_item(mk_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1));
	endtask

	// two separate cells per cursor move fill the table and drop the last two
	task automatic test_table_overflow();
		for (int k = 0; k < 9; k++)
			send_item(mk_item(REQ_CURSOR, 2 * k, 0, 2, 0, 2 * k, 0, 1'b1));
		send_item(mk_item(REQ_REPORT, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(REQ_REPORT, 0, 0, 0, 0, 0, 0, 1'b0));
	endtask

	task automatic test_random_traffic(input int pct, input int count);
		int goal;
		idle_pct = pct;
		goal = n_items + count;
		while (n_items < goal)
			send_item(random_item());
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		clear_damage();
		cur_shown = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 29;
		test_empty_and_span();
		test_merge_and_cursor();
		test_table_overflow();
		test_random_traffic(29, 165);
		test_random_traffic(55, 165);
		test_random_traffic(0, 170);
		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d request items with %0d reports, %0d results checked",
			n_items, n_reports, n_results);
		$display("reports taken after rectangles were dropped: %0d, errors: %0d",
			n_full_reports, n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
